// File: hdl/swl_pkg.sv
// ----------------------------------------------------------------------------
// swl_pkg
// shared types, opcodes, character codes and divide constants for the
// stopwatch with laps
// ----------------------------------------------------------------------------
package swl_pkg;

    // input beat: tick or received byte
    typedef struct packed {
        logic       command;
        logic [7:0] cmd_byte;
    } in_beat_t;

    // result beat
    typedef struct packed {
        logic [2:0]  event_res;
        logic [1:0]  run_state;
        logic [31:0] reported_ms;
        logic [10:0] hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
        logic [9:0]  millis;
        logic [3:0]  laps_stored;
        logic [31:0] last_lap_ms;
    } out_beat_t;

    // classified operation passed from front to back
    typedef enum logic [2:0] {
        OP_NONE       = 3'd0,
        OP_TICK       = 3'd1,
        OP_START_STOP = 3'd2,
        OP_CLEAR      = 3'd3,
        OP_LAP        = 3'd4
    } op_t;

    // record leaving the state update, before the time split
    typedef struct packed {
        logic [2:0]  event_res;
        logic [1:0]  run_state;
        logic [31:0] reported_ms;
        logic [3:0]  laps_stored;
        logic [31:0] last_lap_ms;
    } rec_t;

    // event codes
    localparam logic [2:0] EV_NONE  = 3'd0;
    localparam logic [2:0] EV_START = 3'd1;
    localparam logic [2:0] EV_STOP  = 3'd2;
    localparam logic [2:0] EV_RESET = 3'd3;
    localparam logic [2:0] EV_LAP   = 3'd4;

    // character codes, lower case after folding
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;
    localparam logic [7:0] CH_S        = 8'h73;
    localparam logic [7:0] CH_R        = 8'h72;
    localparam logic [7:0] CH_L        = 8'h6C;

    // command queue
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // time split constants
    localparam logic [9:0]  MS_PER_S  = 10'd1000;
    localparam logic [5:0]  PER_MIN   = 6'd60;
    // floor(x / 1000) = (x * MS_RECIP) >> 38, exact for 32-bit x
    localparam logic [28:0] MS_RECIP  = 29'd274877907;
    // floor(n / 60) = (n * SEC_RECIP) >> 29, exact for n below 2^23
    localparam logic [23:0] SEC_RECIP = 24'd8947849;
    // floor(n / 60) = (n * MIN_RECIP) >> 23, exact for n below 2^17
    localparam logic [17:0] MIN_RECIP = 18'd139811;

endpackage

// File: hdl/swl_front.sv
// ----------------------------------------------------------------------------
// swl_front
// takes input beats and classifies them into operations for the queue
// ----------------------------------------------------------------------------
module swl_front (
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  swl_pkg::in_beat_t cmd_data,
    input  logic             q_full,
    output logic             push,
    output swl_pkg::op_t     push_op
);

    logic [7:0] folded;

    assign cmd_stall = q_full;
    assign push      = cmd_valid && !q_full;

    always_comb
    begin
        folded = cmd_data.cmd_byte;
        if (folded >= swl_pkg::CH_UPPER_A && folded <= swl_pkg::CH_UPPER_Z)
        begin
            folded = folded + swl_pkg::CASE_OFFSET;
        end
        if (!cmd_data.command)
        begin
            push_op = swl_pkg::OP_TICK;
        end
        else
        begin
            unique case (folded)
                swl_pkg::CH_S: push_op = swl_pkg::OP_START_STOP;
                swl_pkg::CH_R: push_op = swl_pkg::OP_CLEAR;
                swl_pkg::CH_L: push_op = swl_pkg::OP_LAP;
                default:       push_op = swl_pkg::OP_NONE;
            endcase
        end
    end

endmodule

// File: hdl/swl_queue.sv
// ----------------------------------------------------------------------------
// swl_queue
// short operation queue between front and back
// ----------------------------------------------------------------------------
module swl_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  swl_pkg::op_t push_op,
    output logic         full,
    input  logic         pop,
    output logic         nonempty,
    output swl_pkg::op_t head_op
);

    swl_pkg::op_t               entry_reg [swl_pkg::Q_DEPTH];
    logic [swl_pkg::Q_AW-1:0]   wr_ptr_reg;
    logic [swl_pkg::Q_AW-1:0]   rd_ptr_reg;
    logic [swl_pkg::Q_AW:0]     count_reg;
    logic [swl_pkg::Q_AW:0]     count_next;

    assign full     = (count_reg == (swl_pkg::Q_AW+1)'(swl_pkg::Q_DEPTH));
    assign nonempty = (count_reg != '0);
    assign head_op  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (swl_pkg::Q_AW+1)'(swl_pkg::Q_DEPTH))
        else $error("queue count above depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && count_reg == '0))
        else $error("queue popped while empty");

endmodule

// File: hdl/swl_back.sv
// ----------------------------------------------------------------------------
// swl_back
// watch state machine: carries out, while adv is high, one queued operation per cycle
// ----------------------------------------------------------------------------
module swl_back #(
    parameter int LAP_LIMIT = 10
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         adv,
    input  logic         nonempty,
    input  swl_pkg::op_t head_op,
    output logic         pop,
    output swl_pkg::rec_t rec,
    output logic         rec_valid
);

    typedef enum logic [1:0] {
        READY   = 2'd0,
        RUNNING = 2'd1,
        PAUSED  = 2'd2
    } watch_state_t;

    watch_state_t  state_reg;
    watch_state_t  state_next;
    logic [31:0]   elapsed_reg;
    logic [31:0]   elapsed_next;
    logic [3:0]    lap_total_reg;
    logic [3:0]    lap_total_next;
    logic [31:0]   newest_lap_reg;
    logic [31:0]   newest_lap_next;
    logic [2:0]    event_next;
    swl_pkg::rec_t rec_reg;
    logic          rec_valid_reg;

    assign pop       = nonempty && adv;
    assign rec       = rec_reg;
    assign rec_valid = rec_valid_reg;

    always_comb
    begin
        state_next      = state_reg;
        elapsed_next    = elapsed_reg;
        lap_total_next  = lap_total_reg;
        newest_lap_next = newest_lap_reg;
        event_next      = swl_pkg::EV_NONE;
        unique case (head_op)
            swl_pkg::OP_TICK:
            begin
                if (state_reg == RUNNING)
                begin
                    elapsed_next = elapsed_reg + 32'd1;
                end
            end
            swl_pkg::OP_START_STOP:
            begin
                if (state_reg == RUNNING)
                begin
                    state_next = PAUSED;
                    event_next = swl_pkg::EV_STOP;
                end
                else
                begin
                    state_next = RUNNING;
                    event_next = swl_pkg::EV_START;
                end
            end
            swl_pkg::OP_CLEAR:
            begin
                state_next      = READY;
                elapsed_next    = '0;
                lap_total_next  = '0;
                newest_lap_next = '0;
                event_next      = swl_pkg::EV_RESET;
            end
            swl_pkg::OP_LAP:
            begin
                if (state_reg == RUNNING && lap_total_reg < 4'(LAP_LIMIT))
                begin
                    newest_lap_next = elapsed_reg;
                    lap_total_next  = lap_total_reg + 4'd1;
                    event_next      = swl_pkg::EV_LAP;
                end
            end
            swl_pkg::OP_NONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= READY;
            elapsed_reg    <= '0;
            lap_total_reg  <= '0;
            newest_lap_reg <= '0;
            rec_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                state_reg      <= state_next;
                elapsed_reg    <= elapsed_next;
                lap_total_reg  <= lap_total_next;
                newest_lap_reg <= newest_lap_next;
            end
            if (adv)
            begin
                rec_valid_reg         <= nonempty;
                rec_reg.event_res     <= event_next;
                rec_reg.run_state     <= 2'(state_next);
                rec_reg.reported_ms   <= (event_next == swl_pkg::EV_LAP) ?
                                         newest_lap_next : elapsed_next;
                rec_reg.laps_stored   <= lap_total_next;
                rec_reg.last_lap_ms   <= newest_lap_next;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        lap_total_reg <= 4'(LAP_LIMIT))
        else $error("lap count above limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid_reg && rec_reg.event_res == swl_pkg::EV_LAP)
        |-> (rec_reg.run_state == 2'(RUNNING)))
        else $error("lap recorded outside running");

    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head_op == swl_pkg::OP_CLEAR)
        |=> (state_reg == READY && elapsed_reg == '0 && lap_total_reg == '0))
        else $error("clear did not return to ready");

endmodule

// File: hdl/swl_split.sv
// ----------------------------------------------------------------------------
// swl_split
// splits the reported time into h/m/s/ms by reciprocal multiplies
// ----------------------------------------------------------------------------
module swl_split (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  swl_pkg::rec_t      rec,
    input  logic               rec_valid,
    output swl_pkg::out_beat_t res_data,
    output logic               res_valid
);

    swl_pkg::rec_t      s1_rec_reg;
    logic [60:0]        p1_reg;
    logic               v1_reg;

    swl_pkg::rec_t      s2_rec_reg;
    logic [22:0]        q1_reg;
    logic [9:0]         ms2_reg;
    logic [46:0]        p2_reg;
    logic               v2_reg;

    swl_pkg::rec_t      s3_rec_reg;
    logic [9:0]         ms3_reg;
    logic [5:0]         sec_reg;
    logic [16:0]        q2_reg;
    logic [34:0]        p3_reg;
    logic               v3_reg;

    swl_pkg::out_beat_t res_reg;
    logic               res_valid_reg;

    logic [22:0]        q1;
    logic [31:0]        ms_full;
    logic [16:0]        q2;
    logic [22:0]        sec_full;
    logic [10:0]        hrs;
    logic [16:0]        min_full;

    assign q1       = p1_reg[60:38];
    assign ms_full  = s1_rec_reg.reported_ms - 32'(q1) * 32'(swl_pkg::MS_PER_S);
    assign q2       = p2_reg[45:29];
    assign sec_full = q1_reg - 23'(q2) * 23'(swl_pkg::PER_MIN);
    assign hrs      = p3_reg[33:23];
    assign min_full = q2_reg - 17'(hrs) * 17'(swl_pkg::PER_MIN);

    assign res_data  = res_reg;
    assign res_valid = res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= rec_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            res_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // ms reciprocal product
            s1_rec_reg <= rec;
            p1_reg     <= 61'(rec.reported_ms) * 61'(swl_pkg::MS_RECIP);

            // whole seconds, millis, minute reciprocal product
            s2_rec_reg <= s1_rec_reg;
            q1_reg     <= q1;
            ms2_reg    <= ms_full[9:0];
            p2_reg     <= 47'(q1) * 47'(swl_pkg::SEC_RECIP);

            // whole minutes, seconds, hour reciprocal product
            s3_rec_reg <= s2_rec_reg;
            ms3_reg    <= ms2_reg;
            sec_reg    <= sec_full[5:0];
            q2_reg     <= q2;
            p3_reg     <= 35'(q2) * 35'(swl_pkg::MIN_RECIP);

            // result beat
            res_reg.event_res   <= s3_rec_reg.event_res;
            res_reg.run_state   <= s3_rec_reg.run_state;
            res_reg.reported_ms <= s3_rec_reg.reported_ms;
            res_reg.hours       <= hrs;
            res_reg.minutes     <= min_full[5:0];
            res_reg.seconds     <= sec_reg;
            res_reg.millis      <= ms3_reg;
            res_reg.laps_stored <= s3_rec_reg.laps_stored;
            res_reg.last_lap_ms <= s3_rec_reg.last_lap_ms;
        end
    end

endmodule

// File: hdl/stopwatch_with_laps.sv
// path: queue, back record register, split registers s1 to s3, result register
// throughput: one beat per cycle, no bubbles while the result side is not stalled
// a stalled result freezes the whole back pipeline; the two-entry queue then
// fills and the input side stalls once both entries are taken
// reset: asynchronous, active low; watch ready, elapsed, lap count and last lap zero
// ----------------------------------------------------------------------------
// stopwatch_with_laps
// millisecond stopwatch with start/stop, clear and lap commands, reporting
// the time split into hours, minutes, seconds and milliseconds
// ----------------------------------------------------------------------------
module stopwatch_with_laps #(
    parameter int LAP_LIMIT = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  swl_pkg::in_beat_t  cmd_data,
    output logic               res_valid,
    input  logic               res_stall,
    output swl_pkg::out_beat_t res_data
);

    // front to queue
    logic          push;
    swl_pkg::op_t  push_op;
    logic          q_full;

    // queue to back
    logic          pop;
    logic          q_nonempty;
    swl_pkg::op_t  head_op;

    // back to split
    swl_pkg::rec_t rec;
    logic          rec_valid;

    // the back pipeline moves as one; it holds only while a result beat waits
    logic          adv;

    assign adv = !(res_valid && res_stall);

    // front: fold case and classify each beat into an operation
    swl_front u_front (
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .q_full    (q_full),
        .push      (push),
        .push_op   (push_op)
    );

    // queue: decouples input acceptance from a stalled back pipeline
    swl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_op  (push_op),
        .full     (q_full),
        .pop      (pop),
        .nonempty (q_nonempty),
        .head_op  (head_op)
    );

    // back: watch state, elapsed count, lap register; one op per cycle while adv
    swl_back #(
        .LAP_LIMIT (LAP_LIMIT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .nonempty  (q_nonempty),
        .head_op   (head_op),
        .pop       (pop),
        .rec       (rec),
        .rec_valid (rec_valid)
    );

    // split: three registered reciprocal multiplies, then the result register
    swl_split u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .rec       (rec),
        .rec_valid (rec_valid),
        .res_data  (res_data),
        .res_valid (res_valid)
    );

endmodule
